### rtl/core/tetra_volume_gamut_clip_assert.svh
// assertion macros for the tetra volume and gamut clip block
// used by the checker; no other dependencies
`ifndef TETRA_VOLUME_GAMUT_CLIP_ASSERT_SVH
`define TETRA_VOLUME_GAMUT_CLIP_ASSERT_SVH

// condition holds in the same cycle
`define TVGC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the next cycle
`define TVGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tvgc_pkg.sv
// shared types, widths and helpers for the tetra volume and gamut clip block
// no dependencies
package tvgc_pkg;

  localparam int LAB_W      = 16;
  localparam int RGB_W      = 15;
  localparam int DIF_W      = 17;
  localparam int CRS_W      = 35;
  localparam int PRD_W      = 52;
  localparam int DET_W      = 55;
  localparam int VOL_W      = 52;
  localparam int SUM_W      = 63;
  localparam int CNT_OUT_W  = 6;
  localparam int STEP_W     = 4;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DAT_W  = 8;
  localparam int SLACK_W    = 8;
  localparam int FULL_SCALE = 4096;

  localparam logic [SUM_W-1:0]  SUM_MAX   = '1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = 2'd3;

  // determinant sequencer steps, one product issued per step
  localparam logic [STEP_W-1:0] ST_CX_A   = 4'd0;
  localparam logic [STEP_W-1:0] ST_CX_B   = 4'd1;
  localparam logic [STEP_W-1:0] ST_CY_A   = 4'd2;
  localparam logic [STEP_W-1:0] ST_CY_B   = 4'd3;
  localparam logic [STEP_W-1:0] ST_CZ_A   = 4'd4;
  localparam logic [STEP_W-1:0] ST_CZ_B   = 4'd5;
  localparam logic [STEP_W-1:0] ST_DX     = 4'd6;
  localparam logic [STEP_W-1:0] ST_DY     = 4'd7;
  localparam logic [STEP_W-1:0] ST_DZ     = 4'd8;
  localparam logic [STEP_W-1:0] MUL_STEPS = 4'd9;
  localparam logic [STEP_W-1:0] DET_STEPS = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMUT_SLACK = 8'd1;

  typedef struct packed {
    logic              take;
    logic [SLOT_W-1:0] slot;
    logic              init;
    logic              mul_en;
    logic [STEP_W-1:0] step;
    logic              cnt_en;
    logic              abs_en;
    logic              prod_en;
    logic              accum;
  } tvgc_cmd_t;

  typedef struct packed {
    logic cnt_done;
  } tvgc_sts_t;

  // msb of the result is the saturation flag
  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] s,
                                             input logic [SUM_W:0]   a);
    logic [SUM_W+1:0] t;
    t = {2'b00, s} + {1'b0, a};
    if (t > {2'b00, SUM_MAX}) begin
      return {1'b1, SUM_MAX};
    end
    return {1'b0, t[SUM_W-1:0]};
  endfunction

endpackage

### rtl/core/tvgc_if.sv
// input, result and config channels of the tetra volume and gamut clip block
// depends on tvgc_pkg
interface tvgc_in_if import tvgc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAB_W-1:0] lightness;
  logic signed [LAB_W-1:0] green_red;
  logic signed [LAB_W-1:0] blue_yellow;
  logic signed [RGB_W-1:0] red_level;
  logic signed [RGB_W-1:0] green_level;
  logic signed [RGB_W-1:0] blue_level;
  logic                    new_set;
  modport source(output valid, lightness, green_red, blue_yellow, red_level,
                 green_level, blue_level, new_set, input ready);
  modport sink(input valid, lightness, green_red, blue_yellow, red_level,
               green_level, blue_level, new_set, output ready);
endinterface

interface tvgc_out_if import tvgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VOL_W-1:0]     volume_x6;
  logic [CNT_OUT_W-1:0] inside_count;
  logic [SUM_W-1:0]     volume_total;
  logic [SUM_W-1:0]     clipped_total;
  logic                 overflow;
  modport source(output valid, volume_x6, inside_count, volume_total,
                 clipped_total, overflow, input ready);
  modport sink(input valid, volume_x6, inside_count, volume_total,
               clipped_total, overflow, output ready);
endinterface

interface tvgc_cfg_if import tvgc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/tetra_volume_gamut_clip.sv
// after the 4th corner the block runs the nine-product shared multiplier
// sequence and, alongside it, the lattice scan when it runs (56 points at
// order 6), then takes the absolute value, the product and the sums; corners
// 1-3 are taken one per cycle while idle, no corner until the result is handed off
// reset: synchronous active high, clears sums, overflow and slot, config to defaults
module tetra_volume_gamut_clip import tvgc_pkg::*; #(
  parameter int LATTICE_ORDER = 6
) (
  input  logic clk,
  input  logic rst,
  tvgc_in_if.sink    in_ch,
  tvgc_out_if.source out_ch,
  tvgc_cfg_if.sink   cfg_ch
);

  tvgc_cmd_t cmd;
  tvgc_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  tvgc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tvgc_dp #(
    .LATTICE_ORDER(LATTICE_ORDER)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .lightness     (in_ch.lightness),
    .green_red     (in_ch.green_red),
    .blue_yellow   (in_ch.blue_yellow),
    .red_level     (in_ch.red_level),
    .green_level   (in_ch.green_level),
    .blue_level    (in_ch.blue_level),
    .new_set       (in_ch.new_set),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .volume_x6     (out_ch.volume_x6),
    .inside_count  (out_ch.inside_count),
    .volume_total  (out_ch.volume_total),
    .clipped_total (out_ch.clipped_total),
    .overflow      (out_ch.overflow)
  );

endmodule

### rtl/core/tvgc_ctrl.sv
// controller: corner slots, determinant step sequencing, result handoff
// depends on tvgc_pkg
module tvgc_ctrl import tvgc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tvgc_cmd_t cmd,
  input  tvgc_sts_t sts
);

  typedef enum logic [2:0] {S_IDLE, S_WORK, S_ABS, S_PROD, S_ACC} state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic [STEP_W-1:0] step;
  logic              take;
  logic              free;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slot      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accum) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (slot == LAST_SLOT) begin
              slot  <= '0;
              step  <= '0;
              state <= S_WORK;
            end else begin
              slot <= slot + 1'b1;
            end
          end
        end
        S_WORK: begin
          if (step != DET_STEPS) begin
            step <= step + 1'b1;
          end else if (sts.cnt_done) begin
            state <= S_ABS;
          end
        end
        S_ABS:  state <= S_PROD;
        S_PROD: state <= S_ACC;
        S_ACC: begin
          if (free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.take    = take;
    cmd.slot    = slot;
    cmd.step    = step;
    cmd.init    = (state == S_WORK) && (step == '0);
    cmd.mul_en  = (state == S_WORK) && (step < MUL_STEPS);
    cmd.cnt_en  = (state == S_WORK) && (step != '0);
    cmd.abs_en  = (state == S_ABS);
    cmd.prod_en = (state == S_PROD);
    cmd.accum   = (state == S_ACC) && free;
  end

endmodule

### rtl/core/tvgc_dp.sv
// datapath: held corners, shared determinant multiplier, lattice counter,
// saturating sums and result register; depends on tvgc_pkg
module tvgc_dp import tvgc_pkg::*; #(
  parameter int LATTICE_ORDER = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  tvgc_cmd_t               cmd,
  output tvgc_sts_t               sts,
  input  logic signed [LAB_W-1:0] lightness,
  input  logic signed [LAB_W-1:0] green_red,
  input  logic signed [LAB_W-1:0] blue_yellow,
  input  logic signed [RGB_W-1:0] red_level,
  input  logic signed [RGB_W-1:0] green_level,
  input  logic signed [RGB_W-1:0] blue_level,
  input  logic                    new_set,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  output logic [VOL_W-1:0]        volume_x6,
  output logic [CNT_OUT_W-1:0]    inside_count,
  output logic [SUM_W-1:0]        volume_total,
  output logic [SUM_W-1:0]        clipped_total,
  output logic                    overflow
);

  localparam int TOTAL  = LATTICE_ORDER * (LATTICE_ORDER + 1) * (LATTICE_ORDER + 2) / 6;
  localparam int CNW    = $clog2(TOTAL + 1);
  localparam int CW     = $clog2(LATTICE_ORDER);
  localparam int WW     = CW + 2;
  localparam int SW     = RGB_W + WW + 3;
  localparam int FOUR_N = 4 * LATTICE_ORDER;
  localparam int EXT_W  = (CNW > CNT_OUT_W) ? CNW : CNT_OUT_W;
  localparam int WP_W   = VOL_W + CNW;
  localparam logic [CW+1:0] NM1   = (CW + 2)'(LATTICE_ORDER - 1);
  localparam logic [CW-1:0] I_END = CW'(LATTICE_ORDER - 1);

  // config
  logic               clip_enable;
  logic [SLACK_W-1:0] gamut_slack;

  // held corners, slot 3 holds the closing corner
  logic signed [LAB_W-1:0] lab_q [4][3];
  logic signed [RGB_W-1:0] rgb_q [4][3];

  // determinant
  logic signed [DIF_W-1:0] u [3];
  logic signed [DIF_W-1:0] v [3];
  logic signed [DIF_W-1:0] w [3];
  logic signed [DIF_W-1:0] mul_a;
  logic signed [CRS_W-1:0] mul_b;
  logic signed [PRD_W-1:0] p;
  logic                    p_valid;
  logic [STEP_W-1:0]       p_step;
  logic signed [CRS_W-1:0] cx, cy, cz;
  logic signed [DET_W-1:0] det;
  logic [VOL_W-1:0]        vol;
  logic [WP_W-1:0]         wprod;

  // lattice count
  logic [CNW-1:0]           cnt;
  logic                     cnt_busy;
  logic [CW-1:0]            ci, cj, ck, cl;
  logic [CW+1:0]            ijk;
  logic [WW-1:0]            wt [4];
  logic signed [SW-1:0]     lo_b, hi_b;
  logic signed [SW-1:0]     mix;
  logic signed [RGB_W+1:0]  lo_q, hi_q;
  logic                     pt_in;
  logic                     all_in;
  logic                     any_none;
  logic                     below, above;

  // sums
  logic [SUM_W-1:0] volume_sum;
  logic [SUM_W-1:0] clipped_sum;
  logic             sum_overflow;
  logic [SUM_W:0]   va, ca;
  logic [EXT_W-1:0] cnt_ext;

  assign sts.cnt_done = !cnt_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b1;
      gamut_slack <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CLIP_ENABLE) begin
        clip_enable <= cfg_data[0];
      end else if (cfg_index == CFG_GAMUT_SLACK) begin
        gamut_slack <= cfg_data[SLACK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      lab_q[cmd.slot][0] <= lightness;
      lab_q[cmd.slot][1] <= green_red;
      lab_q[cmd.slot][2] <= blue_yellow;
      rgb_q[cmd.slot][0] <= red_level;
      rgb_q[cmd.slot][1] <= green_level;
      rgb_q[cmd.slot][2] <= blue_level;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = DIF_W'(lab_q[1][i]) - DIF_W'(lab_q[0][i]);
      v[i] = DIF_W'(lab_q[2][i]) - DIF_W'(lab_q[0][i]);
      w[i] = DIF_W'(lab_q[3][i]) - DIF_W'(lab_q[0][i]);
    end
  end

  always_comb begin
    unique case (cmd.step)
      ST_CX_A: begin mul_a = v[1]; mul_b = CRS_W'(w[2]); end
      ST_CX_B: begin mul_a = v[2]; mul_b = CRS_W'(w[1]); end
      ST_CY_A: begin mul_a = v[2]; mul_b = CRS_W'(w[0]); end
      ST_CY_B: begin mul_a = v[0]; mul_b = CRS_W'(w[2]); end
      ST_CZ_A: begin mul_a = v[0]; mul_b = CRS_W'(w[1]); end
      ST_CZ_B: begin mul_a = v[1]; mul_b = CRS_W'(w[0]); end
      ST_DX:   begin mul_a = u[0]; mul_b = cx; end
      ST_DY:   begin mul_a = u[1]; mul_b = cy; end
      ST_DZ:   begin mul_a = u[2]; mul_b = cz; end
      default: begin mul_a = '0;   mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    p      <= PRD_W'(mul_a) * PRD_W'(mul_b);
    p_step <= cmd.step;
    if (cmd.init) begin
      det <= '0;
    end else if (p_valid) begin
      unique case (p_step)
        ST_CX_A: cx  <= p[CRS_W-1:0];
        ST_CX_B: cx  <= cx - p[CRS_W-1:0];
        ST_CY_A: cy  <= p[CRS_W-1:0];
        ST_CY_B: cy  <= cy - p[CRS_W-1:0];
        ST_CZ_A: cz  <= p[CRS_W-1:0];
        ST_CZ_B: cz  <= cz - p[CRS_W-1:0];
        default: det <= det + DET_W'(p);
      endcase
    end
    if (cmd.abs_en) begin
      vol <= det[DET_W-1] ? VOL_W'(-det) : VOL_W'(det);
    end
    if (cmd.prod_en) begin
      wprod <= WP_W'(vol) * WP_W'(cnt);
    end
  end

  // bounds of the gamut test, scaled by 4n for the lattice mixes
  always_comb begin
    lo_q = (RGB_W + 2)'(0) - (RGB_W + 2)'(gamut_slack);
    hi_q = (RGB_W + 2)'(FULL_SCALE) + (RGB_W + 2)'(gamut_slack);
    lo_b = SW'(0) - SW'(32'(gamut_slack) * 32'(FOUR_N));
    hi_b = SW'((32'(FULL_SCALE) + 32'(gamut_slack)) * 32'(FOUR_N));
  end

  // corners all inside, or one channel wholly beyond a bound
  always_comb begin
    all_in   = 1'b1;
    any_none = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      below = 1'b1;
      above = 1'b1;
      for (int c = 0; c < 4; c++) begin
        if ((RGB_W + 2)'(rgb_q[c][ch]) < lo_q || (RGB_W + 2)'(rgb_q[c][ch]) > hi_q) begin
          all_in = 1'b0;
        end
        if ((RGB_W + 2)'(rgb_q[c][ch]) >= lo_q) begin
          below = 1'b0;
        end
        if ((RGB_W + 2)'(rgb_q[c][ch]) <= hi_q) begin
          above = 1'b0;
        end
      end
      if (below || above) begin
        any_none = 1'b1;
      end
    end
  end

  // one lattice point per cycle
  always_comb begin
    ijk   = (CW + 2)'(ci) + (CW + 2)'(cj) + (CW + 2)'(ck);
    cl    = CW'(NM1 - ijk);
    wt[0] = {ci, 2'b01};
    wt[1] = {cj, 2'b01};
    wt[2] = {ck, 2'b01};
    wt[3] = {cl, 2'b01};
    pt_in = 1'b1;
    for (int ch = 0; ch < 3; ch++) begin
      mix = '0;
      for (int c = 0; c < 4; c++) begin
        mix = mix + SW'(rgb_q[c][ch]) * SW'($signed({1'b0, wt[c]}));
      end
      if (mix < lo_b || mix > hi_b) begin
        pt_in = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_busy <= 1'b0;
    end else if (cmd.init) begin
      cnt_busy <= !(all_in || any_none);
    end else if (cmd.cnt_en && cnt_busy && ci == I_END) begin
      cnt_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cnt <= all_in ? CNW'(TOTAL) : '0;
      ci  <= '0;
      cj  <= '0;
      ck  <= '0;
    end else if (cmd.cnt_en && cnt_busy) begin
      if (pt_in) begin
        cnt <= cnt + 1'b1;
      end
      if (ijk < NM1) begin
        ck <= ck + 1'b1;
      end else if ((CW + 2)'(ci) + (CW + 2)'(cj) < NM1) begin
        ck <= '0;
        cj <= cj + 1'b1;
      end else begin
        ck <= '0;
        cj <= '0;
        ci <= ci + 1'b1;
      end
    end
  end

  always_comb begin
    va      = sat_add(volume_sum, (SUM_W + 1)'(vol));
    ca      = sat_add(clipped_sum, (SUM_W + 1)'(wprod));
    cnt_ext = EXT_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_sum   <= '0;
      clipped_sum  <= '0;
      sum_overflow <= 1'b0;
    end else if (cmd.take && new_set) begin
      volume_sum   <= '0;
      clipped_sum  <= '0;
      sum_overflow <= 1'b0;
    end else if (cmd.accum) begin
      volume_sum <= va[SUM_W-1:0];
      if (clip_enable) begin
        clipped_sum <= ca[SUM_W-1:0];
      end
      sum_overflow <= sum_overflow | va[SUM_W] | (clip_enable & ca[SUM_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      volume_x6     <= vol;
      inside_count  <= (cnt_ext > EXT_W'(2**CNT_OUT_W - 1)) ? '1 : cnt_ext[CNT_OUT_W-1:0];
      volume_total  <= va[SUM_W-1:0];
      clipped_total <= clip_enable ? ca[SUM_W-1:0] : clipped_sum;
      overflow      <= sum_overflow | va[SUM_W] | (clip_enable & ca[SUM_W]);
    end
  end

endmodule

### rtl/core/tvgc_checker.sv
// port-level checks for the tetra volume and gamut clip block, with bind
// depends on tvgc_pkg and tetra_volume_gamut_clip_assert.svh
`include "tetra_volume_gamut_clip_assert.svh"

module tvgc_checker import tvgc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VOL_W-1:0] volume_x6,
  input logic [SUM_W-1:0] volume_total,
  input logic [SUM_W-1:0] clipped_total,
  input logic             overflow
);

  `TVGC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped before taken")
  `TVGC_ASSERT_SAME(a_ovf_sat, clk, rst, out_valid && overflow, volume_total == SUM_MAX || clipped_total == SUM_MAX, "overflow without a saturated sum")
  `TVGC_ASSERT_SAME(a_total_ge, clk, rst, out_valid, volume_total >= SUM_W'(volume_x6), "volume total below this volume")

endmodule

bind tetra_volume_gamut_clip tvgc_checker u_tvgc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .volume_x6     (out_ch.volume_x6),
  .volume_total  (out_ch.volume_total),
  .clipped_total (out_ch.clipped_total),
  .overflow      (out_ch.overflow)
);

### dv/tetra_volume_gamut_clip_test.sv
// testbench for the tetra volume and gamut clip block: streams corners, predicts
// each tetra result in sv and compares it field by field; depends on tvgc_pkg and tvgc_if
module tetra_volume_gamut_clip_test;
  import tvgc_pkg::*;

  localparam int ORDER = 6;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [LAB_W-1:0] l, a, b;
    logic signed [RGB_W-1:0] r, g, bl;
    logic ns;
  } corner_t;

  typedef struct packed {
    logic [VOL_W-1:0] vol;
    logic [CNT_OUT_W-1:0] cnt;
    logic [SUM_W-1:0] vtot, ctot;
    logic ovf;
  } tetra_res_t;

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  tvgc_in_if in_ch();
  tvgc_out_if out_ch();
  tvgc_cfg_if cfg_ch();

  tetra_volume_gamut_clip #(.LATTICE_ORDER(ORDER)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));

  // predictor state
  logic clip_on;
  logic [SLACK_W-1:0] slack;
  longint held_lab[3][3];
  longint held_rgb[3][3];
  int slot;
  logic [SUM_W-1:0] vsum, csum;
  logic ovf_flag;

  tetra_res_t pending_results[$];
  int errors = 0;
  int tetras_seen = 0;
  int corners_sent = 0;
  int idle_cycles = 0;
  bit rx_stall_on = 1;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic longint count_inside(input longint rgb[4][3]);
    longint lo, hi, s, cnt;
    longint w[4];
    bit any_out, below, above, ok;
    lo = -longint'(slack);
    hi = FULL_SCALE + longint'(slack);
    any_out = 0;
    for (int c = 0; c < 4; c++)
      for (int ch = 0; ch < 3; ch++)
        if (rgb[c][ch] < lo || rgb[c][ch] > hi) any_out = 1;
    if (!any_out) return ORDER * (ORDER + 1) * (ORDER + 2) / 6;
    for (int ch = 0; ch < 3; ch++) begin
      below = 1;
      above = 1;
      for (int c = 0; c < 4; c++) begin
        if (rgb[c][ch] >= lo) below = 0;
        if (rgb[c][ch] <= hi) above = 0;
      end
      if (below || above) return 0;
    end
    cnt = 0;
    for (int i = 0; i < ORDER; i++)
      for (int j = 0; i + j < ORDER; j++)
        for (int k = 0; i + j + k < ORDER; k++) begin
          w[0] = 4 * i + 1;
          w[1] = 4 * j + 1;
          w[2] = 4 * k + 1;
          w[3] = 4 * (ORDER - 1 - i - j - k) + 1;
          ok = 1;
          for (int ch = 0; ch < 3; ch++) begin
            s = w[0] * rgb[0][ch] + w[1] * rgb[1][ch] + w[2] * rgb[2][ch]
              + w[3] * rgb[3][ch];
            if (s < lo * 4 * ORDER || s > hi * 4 * ORDER) ok = 0;
          end
          if (ok) cnt++;
        end
    return cnt;
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] s,
                                                input logic [127:0] a);
    logic [127:0] t;
    t = {65'd0, s} + a;
    if (t > {65'd0, SUM_MAX}) begin
      ovf_flag = 1;
      return SUM_MAX;
    end
    return t[SUM_W-1:0];
  endfunction

  // advances the predictor by one corner; true when a tetra result is due
  function automatic bit take_corner(input corner_t c, output tetra_res_t r);
    longint lab[3], rgb[3], u[3], v[3], w[3], cx, cy, cz, det, cnt;
    longint crgb[4][3];
    logic [63:0] vol;
    lab[0] = c.l; lab[1] = c.a; lab[2] = c.b;
    rgb[0] = c.r; rgb[1] = c.g; rgb[2] = c.bl;
    r = '0;
    if (c.ns) begin
      vsum = 0;
      csum = 0;
      ovf_flag = 0;
    end
    if (slot < 3) begin
      for (int i = 0; i < 3; i++) begin
        held_lab[slot][i] = lab[i];
        held_rgb[slot][i] = rgb[i];
      end
      slot++;
      return 0;
    end
    slot = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = held_lab[1][i] - held_lab[0][i];
      v[i] = held_lab[2][i] - held_lab[0][i];
      w[i] = lab[i] - held_lab[0][i];
      for (int k = 0; k < 3; k++) crgb[k][i] = held_rgb[k][i];
      crgb[3][i] = rgb[i];
    end
    cx = v[1] * w[2] - v[2] * w[1];
    cy = v[2] * w[0] - v[0] * w[2];
    cz = v[0] * w[1] - v[1] * w[0];
    det = u[0] * cx + u[1] * cy + u[2] * cz;
    vol = det < 0 ? -det : det;
    cnt = count_inside(crgb);
    vsum = sum_sat(vsum, {64'd0, vol});
    if (clip_on) csum = sum_sat(csum, {64'd0, vol} * cnt);
    r.vol = vol[VOL_W-1:0];
    r.cnt = cnt > 63 ? 6'd63 : cnt[CNT_OUT_W-1:0];
    r.vtot = vsum;
    r.ctot = csum;
    r.ovf = ovf_flag;
    return 1;
  endfunction

  // result checking
  always @(posedge clk) begin
    tetra_res_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_ch.volume_x6, 0);
      end else begin
        e = pending_results.pop_front();
        tetras_seen++;
        if (out_ch.volume_x6 !== e.vol) report("volume_x6", out_ch.volume_x6, e.vol);
        if (out_ch.inside_count !== e.cnt) report("inside_count", out_ch.inside_count, e.cnt);
        if (out_ch.volume_total !== e.vtot) report("volume_total", out_ch.volume_total, e.vtot);
        if (out_ch.clipped_total !== e.ctot)
          report("clipped_total", out_ch.clipped_total, e.ctot);
        if (out_ch.overflow !== e.ovf) report("overflow", out_ch.overflow, e.ovf);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst || !rx_stall_on) begin
      out_ch.ready <= 1;
    end else if (out_ch.valid && out_ch.ready) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else if (!out_ch.ready) begin
      out_ch.ready <= ($urandom_range(0, 15) == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
    end else begin
      out_ch.ready <= 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("tetra_volume_gamut_clip_test: done, errors");
        $finish;
      end
    end
  end

  // a zero gap keeps valid high into the next request
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_corner(input corner_t c);
    tetra_res_t r;
    in_ch.valid <= 1;
    {in_ch.lightness, in_ch.green_red, in_ch.blue_yellow} <= {c.l, c.a, c.b};
    {in_ch.red_level, in_ch.green_level, in_ch.blue_level} <= {c.r, c.g, c.bl};
    in_ch.new_set <= c.ns;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (take_corner(c, r)) pending_results.insert(pending_results.size(), r);
    corners_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    if (idx == CFG_CLIP_ENABLE) clip_on = d[0];
    else if (idx == CFG_GAMUT_SLACK) slack = d;
    @(posedge clk);
  endtask

  function automatic logic signed [RGB_W-1:0] rand_rgb(input int style);
    case (style)
      0: return $urandom_range(0, FULL_SCALE);
      1: return $urandom_range(0, 4700) - 300;
      2: return $urandom_range(0, 32767) - 16384;
      default: return ($urandom_range(0, 1)) ? $urandom_range(4097, 4400)
                                             : -$urandom_range(1, 300);
    endcase
  endfunction

  function automatic corner_t rand_corner(input int style, input int span);
    corner_t c;
    c.l = $urandom_range(0, 2 * span) - span;
    c.a = $urandom_range(0, 2 * span) - span;
    c.b = $urandom_range(0, 2 * span) - span;
    c.r = rand_rgb(style);
    c.g = rand_rgb(style);
    c.bl = rand_rgb(style);
    c.ns = ($urandom_range(0, 60) == 0);
    return c;
  endfunction

  // directed rows; want_cnt < 0 means predictor only
  typedef struct {
    corner_t c;
    int want_cnt;
  } row_t;

  row_t rows[$];
  corner_t zc, mx, mn;
  int big_at;

  initial begin
    tetra_res_t dummy;
    corner_t c;
    int style;
    in_ch.valid = 0;
    {in_ch.lightness, in_ch.green_red, in_ch.blue_yellow} = '0;
    {in_ch.red_level, in_ch.green_level, in_ch.blue_level, in_ch.new_set} = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    clip_on = 1;
    slack = 0;
    slot = 0;
    vsum = 0;
    csum = 0;
    ovf_flag = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    zc = '0;
    mx = '{l: 16'sh7fff, a: 16'sh7fff, b: 16'sh7fff, r: 15'sh3fff, g: 15'sh3fff,
           bl: 15'sh3fff, ns: 1};
    mn = '{l: -16'sh8000, a: -16'sh8000, b: -16'sh8000, r: -15'sh4000, g: -15'sh4000,
           bl: -15'sh4000, ns: 0};
    // degenerate tetra, all corners black: full count, zero volume
    repeat (4) rows.insert(rows.size(), '{zc, ORDER * (ORDER + 1) * (ORDER + 2) / 6});
    // all corners far above scale: count zero
    c = mx; c.ns = 0;
    rows.insert(rows.size(), '{mx, 0});
    repeat (3) rows.insert(rows.size(), '{c, 0});
    // extreme lab span, mixed rgb, new_set mid-tetra
    rows.insert(rows.size(), '{mn, -1});
    c = mx; c.l = -16'sh8000; c.r = 0; c.g = 4096; c.bl = 0;
    rows.insert(rows.size(), '{c, -1});
    c = mn; c.a = 16'sh7fff; c.r = 4096; c.g = 0; c.bl = -15'sh4000; c.ns = 1;
    rows.insert(rows.size(), '{c, -1});
    c = mx; c.b = -16'sh8000; c.ns = 0;
    rows.insert(rows.size(), '{c, -1});
    // partial gamut straddling edges
    c = zc; c.r = -2000; rows.insert(rows.size(), '{c, -1});
    c = zc; c.r = 6000; c.g = 4096; rows.insert(rows.size(), '{c, -1});
    c = zc; c.l = 100; c.g = 4097; rows.insert(rows.size(), '{c, -1});
    c = zc; c.a = 100; c.b = 5; c.bl = -1; rows.insert(rows.size(), '{c, -1});
    foreach (rows[i]) begin
      random_gap();
      send_corner(rows[i].c);
      if (rows[i].want_cnt >= 0 && pending_results.size() != 0 && slot == 0) begin
        dummy = pending_results[$];
        if (dummy.cnt != rows[i].want_cnt) report("directed count", dummy.cnt, rows[i].want_cnt);
      end
    end
    drain();

    // phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_CLIP_ENABLE, 8'd0); write_reg(CFG_GAMUT_SLACK, 8'd255); end
        1: begin write_reg(CFG_CLIP_ENABLE, 8'd1); write_reg(CFG_GAMUT_SLACK, 8'd0); end
        2: write_reg(CFG_GAMUT_SLACK, 8'($urandom_range(1, 254)));
        3: begin write_reg(8'd7, 8'hff); write_reg(CFG_CLIP_ENABLE, 8'hfe); end
        4: begin write_reg(CFG_CLIP_ENABLE, 8'hff); write_reg(CFG_GAMUT_SLACK, 8'haa); end
        default: write_reg(CFG_GAMUT_SLACK, 8'h55);
      endcase
      rx_stall_on = (ph != 5);
      big_at = $urandom_range(0, 30);
      for (int t = 0; t < 36; t++) begin
        style = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          // huge lab spans drive the sums toward saturation
          c = rand_corner(style, (t == big_at || ph == 4) ? 32767 : 2000);
          if (k == 0 && t == 0) c.ns = 1;
          if (ph == 2 && t == 10 && k == 0) begin
            // sender waits for every expected result
            drain();
          end
          if (ph != 5) random_gap();
          send_corner(c);
        end
      end
      drain();
    end

    $display("covered %0d corners and %0d tetra results over six register settings",
             corners_sent, tetras_seen);
    if (errors == 0) begin
      $display("tetra_volume_gamut_clip_test: done, clean");
    end else begin
      $display("tetra_volume_gamut_clip_test: done, errors");
    end
    $finish;
  end

endmodule
